/* src/i2cbs_pkg.sv */
package i2cbs_pkg;

  localparam int unsigned BitsPerByte   = 8;
  localparam int unsigned SlotIdxW      = 5;
  localparam int unsigned TickW         = 16;
  localparam logic [TickW-1:0] SlotTicksReset = TickW'(10);

  // action codes on the input channel
  localparam logic [2:0] ActNone  = 3'd0;
  localparam logic [2:0] ActStart = 3'd1;
  localparam logic [2:0] ActStop  = 3'd2;
  localparam logic [2:0] ActWrite = 3'd3;
  localparam logic [2:0] ActRead  = 3'd4;
  localparam logic [2:0] ActSack  = 3'd5;
  localparam logic [2:0] ActRack  = 3'd6;

  // command being carried out, one-hot
  typedef enum logic [6:0] {
    CmdIdle  = 7'b0000001,
    CmdStart = 7'b0000010,
    CmdStop  = 7'b0000100,
    CmdWrite = 7'b0001000,
    CmdRead  = 7'b0010000,
    CmdSack  = 7'b0100000,
    CmdRack  = 7'b1000000
  } cmd_e;

  typedef enum logic [1:0] {
    OpScl  = 2'd0,
    OpSda  = 2'd1,
    OpRead = 2'd2
  } op_e;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] tx_byte;
    logic       ack_out;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_in;
  } out_item_t;

  // classified tick as queued between front and back
  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] tx_byte;
    logic       ack_out;
    logic       sda_in;
  } cmd_item_t;

  typedef struct packed {
    logic fire;
    logic active;
    logic done;
  } eng_status_t;

  function automatic logic [SlotIdxW-1:0] last_slot(input cmd_e cmd);
    logic [SlotIdxW-1:0] r;
    r = '0;
    unique case (cmd)
      CmdStart: r = SlotIdxW'(3);
      CmdStop:  r = SlotIdxW'(2);
      CmdWrite: r = SlotIdxW'(3 * BitsPerByte - 1);
      CmdRead:  r = SlotIdxW'(3 * BitsPerByte);
      CmdSack:  r = SlotIdxW'(2);
      CmdRack:  r = SlotIdxW'(3);
      default:  r = '0;
    endcase
    return r;
  endfunction

endpackage

/* src/i2cbs_front.sv */
module i2cbs_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  i2cbs_pkg::in_item_t  in_item_i,
  output logic                 head_valid_o,
  output i2cbs_pkg::cmd_item_t head_o,
  input  logic                 head_take_i
);

  i2cbs_pkg::cmd_item_t mem_q [2];
  logic                 wr_ptr_q, wr_ptr_d;
  logic                 rd_ptr_q, rd_ptr_d;
  logic [1:0]           cnt_q, cnt_d;
  i2cbs_pkg::cmd_item_t cls;
  logic                 wr_en, rd_en;

  // action decode, unused codes fall to idle
  always_comb begin
    cls.tx_byte = in_item_i.tx_byte;
    cls.ack_out = in_item_i.ack_out;
    cls.sda_in  = in_item_i.sda_in;
    unique case (in_item_i.action)
      i2cbs_pkg::ActStart: cls.cmd = i2cbs_pkg::CmdStart;
      i2cbs_pkg::ActStop:  cls.cmd = i2cbs_pkg::CmdStop;
      i2cbs_pkg::ActWrite: cls.cmd = i2cbs_pkg::CmdWrite;
      i2cbs_pkg::ActRead:  cls.cmd = i2cbs_pkg::CmdRead;
      i2cbs_pkg::ActSack:  cls.cmd = i2cbs_pkg::CmdSack;
      i2cbs_pkg::ActRack:  cls.cmd = i2cbs_pkg::CmdRack;
      default:             cls.cmd = i2cbs_pkg::CmdIdle;
    endcase
  end

  assign full         = (cnt_q == 2'd2);
  assign wr_en        = push && !full;
  assign head_valid_o = (cnt_q != 2'd0);
  assign rd_en        = head_take_i && head_valid_o;
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_en ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = rd_en ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(wr_en) - 2'(rd_en);
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

/* src/i2cbs_back.sv */
module i2cbs_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   head_valid_i,
  input  i2cbs_pkg::cmd_item_t   head_i,
  output logic                   head_take_o,
  input  logic [i2cbs_pkg::TickW-1:0] slot_ticks_i,
  output logic                   empty,
  input  logic                   pop,
  output i2cbs_pkg::out_item_t   out_item_o,
  output i2cbs_pkg::eng_status_t status_o
);

  localparam int unsigned SW = i2cbs_pkg::SlotIdxW;
  localparam int unsigned TW = i2cbs_pkg::TickW;

  i2cbs_pkg::cmd_e     cmd_q, cmd_d;
  logic [SW-1:0]       slot_q, slot_d;
  logic [1:0]          phase_q, phase_d;
  logic [TW-1:0]       tick_q, tick_d;
  logic [7:0]          shift_q, shift_d;
  logic [7:0]          rxb_q, rxb_d;
  logic                ack_q, ack_d;
  logic                scl_q, scl_d;
  logic                sda_q, sda_d;
  logic                busy, done;
  logic                fire;

  i2cbs_pkg::out_item_t omem_q [2];
  logic                 owr_q, ord_q;
  logic [1:0]           ocnt_q;
  logic                 opop;

  assign fire        = head_valid_i && (ocnt_q != 2'd2);
  assign head_take_o = fire;

  // one tick of the bit engine
  always_comb begin
    i2cbs_pkg::op_e op;
    logic           lvl;
    logic [TW-1:0]  eff;
    cmd_d   = cmd_q;
    slot_d  = slot_q;
    phase_d = phase_q;
    tick_d  = tick_q;
    shift_d = shift_q;
    rxb_d   = rxb_q;
    ack_d   = ack_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    busy    = 1'b0;
    done    = 1'b0;
    op      = i2cbs_pkg::OpScl;
    lvl     = scl_q;
    eff     = (slot_ticks_i == '0) ? TW'(1) : slot_ticks_i;

    // a new command only starts from idle
    if (cmd_q == i2cbs_pkg::CmdIdle && head_i.cmd != i2cbs_pkg::CmdIdle) begin
      cmd_d   = head_i.cmd;
      slot_d  = '0;
      phase_d = 2'd0;
      tick_d  = '0;
      if (head_i.cmd == i2cbs_pkg::CmdWrite) begin
        shift_d = head_i.tx_byte;
      end else if (head_i.cmd == i2cbs_pkg::CmdSack) begin
        shift_d = {7'd0, head_i.ack_out};
      end else begin
        shift_d = 8'd0;
      end
    end

    if (cmd_d != i2cbs_pkg::CmdIdle) begin
      busy = 1'b1;
      if (tick_d == '0) begin
        unique case (cmd_d)
          i2cbs_pkg::CmdStart: begin
            op  = (slot_d == SW'(0) || slot_d == SW'(2)) ? i2cbs_pkg::OpSda
                                                         : i2cbs_pkg::OpScl;
            lvl = (slot_d == SW'(0) || slot_d == SW'(1));
          end
          i2cbs_pkg::CmdStop: begin
            op  = (slot_d == SW'(1)) ? i2cbs_pkg::OpScl : i2cbs_pkg::OpSda;
            lvl = (slot_d != SW'(0));
          end
          i2cbs_pkg::CmdWrite: begin
            op  = (phase_d == 2'd0) ? i2cbs_pkg::OpSda : i2cbs_pkg::OpScl;
            lvl = (phase_d == 2'd0) ? shift_d[7] : (phase_d == 2'd1);
          end
          i2cbs_pkg::CmdRead: begin
            if (slot_d == SW'(0)) begin
              op  = i2cbs_pkg::OpSda;
              lvl = 1'b1;
            end else if (phase_d == 2'd2) begin
              op  = i2cbs_pkg::OpRead;
              lvl = 1'b1;
            end else begin
              op  = i2cbs_pkg::OpScl;
              lvl = (phase_d == 2'd1);
            end
          end
          i2cbs_pkg::CmdSack: begin
            op  = (slot_d == SW'(0)) ? i2cbs_pkg::OpSda : i2cbs_pkg::OpScl;
            lvl = (slot_d == SW'(0)) ? shift_d[0] : (slot_d == SW'(1));
          end
          i2cbs_pkg::CmdRack: begin
            if (slot_d == SW'(0)) begin
              op  = i2cbs_pkg::OpSda;
              lvl = 1'b1;
            end else if (slot_d == SW'(2)) begin
              op  = i2cbs_pkg::OpRead;
              lvl = 1'b1;
            end else begin
              op  = i2cbs_pkg::OpScl;
              lvl = (slot_d == SW'(1));
            end
          end
          default: begin
            op  = i2cbs_pkg::OpScl;
            lvl = scl_q;
          end
        endcase

        unique case (op)
          i2cbs_pkg::OpScl: scl_d = lvl;
          i2cbs_pkg::OpSda: begin
            sda_d = lvl;
            if (cmd_d == i2cbs_pkg::CmdWrite) begin
              shift_d = {shift_d[6:0], 1'b0};
            end
          end
          default: begin
            if (cmd_d == i2cbs_pkg::CmdRead) begin
              shift_d = {shift_d[6:0], head_i.sda_in};
            end else begin
              ack_d = head_i.sda_in;
            end
          end
        endcase
      end

      if ({1'b0, tick_d} + (TW+1)'(1) >= {1'b0, eff}) begin
        tick_d = '0;
        if (slot_d == i2cbs_pkg::last_slot(cmd_d)) begin
          done = 1'b1;
          if (cmd_d == i2cbs_pkg::CmdRead) begin
            rxb_d = shift_d;
          end
          cmd_d   = i2cbs_pkg::CmdIdle;
          slot_d  = '0;
          phase_d = 2'd0;
        end else begin
          slot_d  = slot_d + SW'(1);
          phase_d = (phase_d == 2'd2) ? 2'd0 : phase_d + 2'd1;
        end
      end else begin
        tick_d = tick_d + TW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q   <= i2cbs_pkg::CmdIdle;
      slot_q  <= '0;
      phase_q <= 2'd0;
      tick_q  <= '0;
      shift_q <= 8'd0;
      rxb_q   <= 8'd0;
      ack_q   <= 1'b0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
    end else if (fire) begin
      cmd_q   <= cmd_d;
      slot_q  <= slot_d;
      phase_q <= phase_d;
      tick_q  <= tick_d;
      shift_q <= shift_d;
      rxb_q   <= rxb_d;
      ack_q   <= ack_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
    end
  end

  // result queue
  assign empty      = (ocnt_q == 2'd0);
  assign opop       = pop && !empty;
  assign out_item_o = omem_q[ord_q];

  always_ff @(posedge clk_i) begin
    if (fire) begin
      omem_q[owr_q] <= '{scl_out: scl_d, sda_out: sda_d, busy_res: busy,
                         done_res: done, rx_byte: rxb_d, ack_in: ack_d};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owr_q  <= 1'b0;
      ord_q  <= 1'b0;
      ocnt_q <= 2'd0;
    end else begin
      owr_q  <= fire ? !owr_q : owr_q;
      ord_q  <= opop ? !ord_q : ord_q;
      ocnt_q <= ocnt_q + 2'(fire) - 2'(opop);
    end
  end

  assign status_o = '{fire: fire, active: (cmd_q != i2cbs_pkg::CmdIdle), done: done};

endmodule

/* src/i2c_master_bit_sequencer.sv */
// channel  | direction | handshake            | payload
// input    | in        | push / full          | in_data_i  (i2cbs_pkg::in_item_t)
// result   | out       | empty / pop          | out_data_o (i2cbs_pkg::out_item_t)
// config   | in        | cfg_valid / cfg_ready| cfg_data_i (slot_ticks, 16 bits)
//
// one tick item in, one result out; the engine retires one tick per clock while
// a tick is queued and results have room, so items flow back to back at one per cycle
// a pushed tick is registered in the input queue, its result in the result queue
// both sides stall on their own through two-entry queues at either end of the engine
// asynchronous active-low reset: lines released, engine idle, slot_ticks = 10
module i2c_master_bit_sequencer (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  i2cbs_pkg::in_item_t  in_data_i,
  output logic                 empty,
  input  logic                 pop,
  output i2cbs_pkg::out_item_t out_data_o,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [15:0]          cfg_data_i
);

  logic [i2cbs_pkg::TickW-1:0] slot_ticks_q;
  logic                        head_valid;
  i2cbs_pkg::cmd_item_t        head;
  logic                        head_take;
  i2cbs_pkg::eng_status_t      eng_st;

  // config register, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_ticks_q <= i2cbs_pkg::SlotTicksReset;
    end else if (cfg_valid && cfg_ready) begin
      slot_ticks_q <= cfg_data_i;
    end
  end

  // front: accept ticks and decode action codes
  i2cbs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .in_item_i    (in_data_i),
    .head_valid_o (head_valid),
    .head_o       (head),
    .head_take_i  (head_take)
  );

  // back: slot sequencer plus result queue
  i2cbs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .head_take_o  (head_take),
    .slot_ticks_i (slot_ticks_q),
    .empty        (empty),
    .pop          (pop),
    .out_item_o   (out_data_o),
    .status_o     (eng_st)
  );

  // a done result is always also busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (!out_data_o.done_res || out_data_o.busy_res))
    else $error("done result without busy");

  // engine is idle the tick after a command finishes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (eng_st.fire && eng_st.done) |=> !eng_st.active)
    else $error("engine still active after done");

  // engine only consumes a queued tick
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    eng_st.fire |-> head_valid)
    else $error("engine fired on empty input queue");

endmodule

/* tb/i2cbs_line_checker.sv */
`timescale 1ns / 100ps

module i2cbs_line_checker
  import i2cbs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  input  logic        full,
  input  in_item_t    in_data_i,
  input  logic        empty,
  input  logic        pop,
  input  out_item_t   out_data_i,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_data_i,
  output int          fail_cnt_o,
  output int          pending_o,
  output int          results_o,
  output int          cmds_o
);

  // bus model state
  logic [15:0] bit_delay;
  logic        scl_q;
  logic        sda_q;
  logic [2:0]  run_cmd;
  logic [4:0]  slot_idx;
  logic [15:0] tick_cnt;
  logic [7:0]  shreg;
  logic [7:0]  rx_q;
  logic        ack_q;

  out_item_t line_q[$];

  function automatic logic [4:0] closing_slot(input logic [2:0] cmd);
    case (cmd)
      ActStart: return 5'd3;
      ActStop:  return 5'd2;
      ActWrite: return 5'd23;
      ActRead:  return 5'd24;
      ActSack:  return 5'd2;
      ActRack:  return 5'd3;
      default:  return 5'd0;
    endcase
  endfunction

  function automatic void decode_slot(input logic [2:0] cmd, input logic [4:0] idx,
                                      output op_e op, output logic lvl);
    logic [4:0] r;
    op  = OpScl;
    lvl = 1'b1;
    case (cmd)
      ActStart: begin
        op  = idx[0] ? OpScl : OpSda;
        lvl = (idx < 5'd2);
      end
      ActStop: begin
        op  = (idx == 5'd1) ? OpScl : OpSda;
        lvl = (idx != 5'd0);
      end
      ActWrite: begin
        r = idx % 5'd3;
        if (r == 5'd0) begin
          op  = OpSda;
          lvl = shreg[7];
        end else begin
          lvl = (r == 5'd1);
        end
      end
      ActRead: begin
        if (idx != 5'd0) begin
          r = (idx - 5'd1) % 5'd3;
          if (r == 5'd1) op = OpRead;
          else lvl = (r == 5'd0);
        end else begin
          op = OpSda;
        end
      end
      ActSack: begin
        if (idx == 5'd0) begin
          op  = OpSda;
          lvl = shreg[0];
        end else begin
          lvl = (idx == 5'd1);
        end
      end
      ActRack: begin
        if (idx == 5'd0) op = OpSda;
        else if (idx == 5'd2) op = OpRead;
        else lvl = (idx == 5'd1);
      end
      default: lvl = scl_q;
    endcase
  endfunction

  // advance the bus by one tick and return what the pins show afterwards
  function automatic out_item_t bus_tick(input in_item_t it);
    out_item_t   res;
    op_e         op;
    logic        lvl;
    logic [15:0] eff;
    res = '0;
    eff = (bit_delay == 16'd0) ? 16'd1 : bit_delay;
    if (run_cmd == ActNone && it.action >= ActStart && it.action <= ActRack) begin
      run_cmd  = it.action;
      slot_idx = '0;
      tick_cnt = '0;
      if (it.action == ActWrite) shreg = it.tx_byte;
      else if (it.action == ActSack) shreg = {7'd0, it.ack_out};
      else shreg = 8'h00;
      cmds_o++;
    end
    if (run_cmd != ActNone) begin
      res.busy_res = 1'b1;
      if (tick_cnt == 16'd0) begin
        decode_slot(run_cmd, slot_idx, op, lvl);
        case (op)
          OpScl: scl_q = lvl;
          OpSda: begin
            sda_q = lvl;
            if (run_cmd == ActWrite) shreg = {shreg[6:0], 1'b0};
          end
          default: begin
            if (run_cmd == ActRead) shreg = {shreg[6:0], it.sda_in};
            else ack_q = it.sda_in;
          end
        endcase
      end
      // a shrunken delay ends the slot at once
      if ({1'b0, tick_cnt} + 17'd1 >= {1'b0, eff}) begin
        tick_cnt = '0;
        if (slot_idx >= closing_slot(run_cmd)) begin
          res.done_res = 1'b1;
          if (run_cmd == ActRead) rx_q = shreg;
          run_cmd  = ActNone;
          slot_idx = '0;
        end else begin
          slot_idx = slot_idx + 5'd1;
        end
      end else begin
        tick_cnt = tick_cnt + 16'd1;
      end
    end
    res.scl_out = scl_q;
    res.sda_out = sda_q;
    res.rx_byte = rx_q;
    res.ack_in  = ack_q;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_item_t want;
    if (!rst_ni) begin
      bit_delay  = SlotTicksReset;
      scl_q      = 1'b1;
      sda_q      = 1'b1;
      run_cmd    = ActNone;
      slot_idx   = '0;
      tick_cnt   = '0;
      shreg      = '0;
      rx_q       = '0;
      ack_q      = 1'b0;
      line_q.delete();
      fail_cnt_o = 0;
      pending_o  = 0;
      results_o  = 0;
      cmds_o     = 0;
    end else begin
      if (cfg_valid && cfg_ready) bit_delay = cfg_data_i;
      if (pop && !empty) begin
        results_o++;
        if (line_q.size() == 0) begin
          fail_cnt_o++;
          if (fail_cnt_o <= 10)
            $display("%0t: unexpected result %h with nothing outstanding", $realtime,
                     out_data_i);
        end else begin
          want = line_q.pop_front();
          if (out_data_i.scl_out !== want.scl_out || out_data_i.sda_out !== want.sda_out ||
              out_data_i.busy_res !== want.busy_res ||
              out_data_i.done_res !== want.done_res ||
              out_data_i.rx_byte !== want.rx_byte || out_data_i.ack_in !== want.ack_in) begin
            fail_cnt_o++;
            if (fail_cnt_o <= 10)
              $display(
                "%0t: #%0d scl/sda/busy/done/rx/ack exp %b/%b/%b/%b/%h/%b got %b/%b/%b/%b/%h/%b",
                $realtime, results_o,
                want.scl_out, want.sda_out, want.busy_res, want.done_res,
                want.rx_byte, want.ack_in, out_data_i.scl_out, out_data_i.sda_out,
                out_data_i.busy_res, out_data_i.done_res, out_data_i.rx_byte,
                out_data_i.ack_in);
          end
        end
      end
      if (push && !full) line_q.push_back(bus_tick(in_data_i));
      pending_o = line_q.size();
    end
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;
  import i2cbs_pkg::*;

  // action code the block must treat like no action
  localparam logic [2:0] ActUnused = 3'd7;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        push      = 1'b0;
  logic        full;
  in_item_t    in_data   = '0;
  logic        empty;
  logic        pop       = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data  = '0;

  // handed up by the checker
  int fails;
  int pending;
  int results;
  int cmds;

  // stimulus bookkeeping
  logic [15:0] cur_delay = SlotTicksReset;
  bit          quiet     = 1'b0;
  int          ticks_sent = 0;

  // per-phase bit delays: small ones keep commands short, zero acts as one,
  // the full-scale value is shrunk again in the middle of a slot
  logic [15:0] delay_plan [9] = '{16'd1, 16'd3, 16'd2, 16'hFFFF, 16'd1, 16'd4, 16'd0,
                                  16'd6, 16'd2};

  always #5 clk = ~clk;

  i2c_master_bit_sequencer dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .push       (push),
    .full       (full),
    .in_data_i  (in_data),
    .empty      (empty),
    .pop        (pop),
    .out_data_o (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data_i (cfg_data)
  );

  i2cbs_line_checker chk (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .push       (push),
    .full       (full),
    .in_data_i  (in_data),
    .empty      (empty),
    .pop        (pop),
    .out_data_i (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data_i (cfg_data),
    .fail_cnt_o (fails),
    .pending_o  (pending),
    .results_o  (results),
    .cmds_o     (cmds)
  );

  // idle length: mostly none or short, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // ticks a command occupies at a given bit delay
  function automatic int cmd_len(input logic [2:0] act, input logic [15:0] dly);
    int slots;
    case (act)
      ActStart: slots = 4;
      ActStop:  slots = 3;
      ActWrite: slots = 24;
      ActRead:  slots = 25;
      ActSack:  slots = 3;
      ActRack:  slots = 4;
      default:  slots = 1;
    endcase
    return slots * ((dly == 16'd0) ? 1 : int'(dly));
  endfunction

  // random tick: commands often enough that the bus is rarely idle for long,
  // plus plain ticks and the unused action code
  function automatic in_item_t rand_tick();
    in_item_t it;
    int       r;
    r = $urandom_range(99);
    if (r < 45) it.action = 3'($urandom_range(ActRack, ActStart));
    else if (r < 53) it.action = ActUnused;
    else it.action = ActNone;
    it.tx_byte = 8'($urandom);
    it.ack_out = 1'($urandom);
    it.sda_in  = 1'($urandom);
    return it;
  endfunction

  // one input transaction; push stays high when the next tick follows at once
  task automatic send_tick(input in_item_t it);
    int g;
    g = quiet ? 0 : pick_gap();
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(posedge clk);
    end
    push    <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (full);
    ticks_sent++;
  endtask

  // start a command from idle and fill its duration with ticks the block must
  // ignore; sda stays at the given level so reads see a known pattern
  task automatic issue_cmd(input logic [2:0] act, input logic [7:0] tx, input logic ack,
                           input logic sda);
    in_item_t it;
    int       n;
    n  = cmd_len(act, cur_delay);
    it = '{action: act, tx_byte: tx, ack_out: ack, sda_in: sda};
    send_tick(it);
    repeat (n - 1) begin
      it.action  = 3'($urandom_range(7));
      it.tx_byte = 8'($urandom);
      it.ack_out = 1'($urandom);
      send_tick(it);
    end
  endtask

  // register write once every outstanding result is back; the bus itself may
  // still be in the middle of a slot
  task automatic set_bit_delay(input logic [15:0] v);
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_delay = v;
  endtask

  // result side: random stalls, bursts of pop in between
  initial begin : pop_side
    int g;
    int b;
    @(posedge rst_n);
    forever begin
      g = pick_gap();
      if (g > 0) begin
        pop <= 1'b0;
        repeat (g) @(posedge clk);
      end
      pop <= 1'b1;
      b = $urandom_range(40, 1);
      repeat (b) @(posedge clk);
    end
  end

  initial begin : stimulus
    in_item_t it;
    int       n;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero delay acts as one tick per slot, every command at least once,
    // byte and line extremes, back to back starts after each done
    set_bit_delay(16'd0);
    issue_cmd(ActStart, 8'h00, 1'b0, 1'b1);
    issue_cmd(ActWrite, 8'hFF, 1'b1, 1'b0);
    issue_cmd(ActWrite, 8'h00, 1'b0, 1'b1);
    issue_cmd(ActRack, 8'hA5, 1'b1, 1'b0);
    issue_cmd(ActRack, 8'h5A, 1'b0, 1'b1);
    issue_cmd(ActRead, 8'h00, 1'b0, 1'b1);
    issue_cmd(ActRead, 8'hFF, 1'b1, 1'b0);
    issue_cmd(ActSack, 8'hFF, 1'b0, 1'b1);
    issue_cmd(ActSack, 8'h00, 1'b1, 1'b0);
    // unused action code while idle changes nothing
    send_tick('{action: ActUnused, tx_byte: 8'hFF, ack_out: 1'b1, sda_in: 1'b0});
    send_tick('{action: ActNone, tx_byte: 8'h00, ack_out: 1'b0, sda_in: 1'b1});
    issue_cmd(ActStop, 8'h3C, 1'b1, 1'b1);

    // random phases, each under its own bit delay
    foreach (delay_plan[ph]) begin
      set_bit_delay(delay_plan[ph]);
      quiet = (ph % 3 == 2);
      n = (delay_plan[ph] == 16'hFFFF) ? 30 : 150;
      repeat (n) begin
        it = rand_tick();
        send_tick(it);
      end
    end

    // drain, then give the block time to show anything extra
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("%0d ticks driven, %0d results checked, %0d commands started", ticks_sent,
             results, cmds);
    $display("bit delays swept from 0 to 65535, register rewritten mid-command");
    if (fails == 0 && pending == 0) begin
      $display("i2c_master_bit_sequencer verification clean");
    end else begin
      $display("i2c_master_bit_sequencer verification failed");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin : watchdog
    #10_000_000;
    $display("i2c_master_bit_sequencer verification failed");
    $finish;
  end

endmodule
